// ===== rtl/hgd_pkg.sv =====
// ----------------------------------------------------------------------------
// hgd_pkg
// Shared types and constants for the Hamming (31,26) group decoder.
// ----------------------------------------------------------------------------
package hgd_pkg;

  // Codeword layout
  localparam int CW_W        = 31;
  localparam int DATA_W      = 26;
  localparam int PAR_W       = 5;

  // Group layout
  localparam int GROUP_WORDS = 4;
  localparam int HELD_WORDS  = GROUP_WORDS - 1;
  localparam int GROUP_BITS  = GROUP_WORDS * DATA_W;
  localparam int BYTE_W      = 8;
  localparam int GROUP_BYTES = GROUP_BITS / BYTE_W;
  localparam int COUNT_W     = 3;
  localparam int WPOS_W      = $clog2(GROUP_WORDS);
  localparam int BIDX_W      = $clog2(GROUP_BYTES);

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // Parity check masks, one per syndrome bit
  localparam logic [DATA_W-1:0] SYN_MASK [PAR_W] = '{
    26'd44739931, 26'd53687917, 26'd63162254, 26'd66848752, 26'd67106816
  };

  // One finished group as it travels from front to back
  typedef struct packed {
    logic [GROUP_BITS-1:0] bits;
    logic [COUNT_W-1:0]    count;
  } group_t;

endpackage

// ===== rtl/hgd_front.sv =====
// ----------------------------------------------------------------------------
// hgd_front
// Accepts codewords, corrects each word and collects groups of four words.
// ----------------------------------------------------------------------------
module hgd_front
  import hgd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CW_W-1:0] in_codeword,
  output logic            push,
  output group_t          push_group,
  input  logic            q_full
);

  logic [DATA_W-1:0] held_r [HELD_WORDS];
  logic [WPOS_W-1:0] wpos_r, wpos_nxt;
  logic [1:0]        tally_r, tally_nxt;

  logic [PAR_W-1:0]  syn;
  logic [DATA_W-1:0] flip;
  logic [DATA_W-1:0] data;
  logic              hit;
  logic              accept;
  logic              last_word;

  // Syndrome from the fixed masks and received parity
  always_comb begin
    for (int k = 0; k < PAR_W; k++) begin
      syn[k] = ^(in_codeword[DATA_W-1:0] & SYN_MASK[k]) ^ in_codeword[DATA_W+k];
    end
  end

  // Map syndrome to a data bit; parity positions and zero flip nothing
  always_comb begin
    flip = '0;
    if (syn == 5'd3) begin
      flip[0] = 1'b1;
    end else if (syn > 5'd4 && syn < 5'd8) begin
      flip[syn - 5'd4] = 1'b1;
    end else if (syn > 5'd8 && syn < 5'd16) begin
      flip[syn - 5'd5] = 1'b1;
    end else if (syn > 5'd16) begin
      flip[syn - 5'd6] = 1'b1;
    end
  end

  assign data = in_codeword[DATA_W-1:0] ^ flip;
  assign hit  = (syn != '0);

  // Only the group-closing word needs room in the queue
  assign last_word = (wpos_r == WPOS_W'(HELD_WORDS));
  assign in_stall  = last_word & q_full;
  assign accept    = in_valid & ~in_stall;
  assign push      = accept & last_word;

  assign push_group.bits  = {data, held_r[2], held_r[1], held_r[0]};
  assign push_group.count = COUNT_W'({1'b0, tally_r}) + COUNT_W'(hit);

  // Word position and correction tally
  always_comb begin
    wpos_nxt  = wpos_r;
    tally_nxt = tally_r;
    if (accept) begin
      if (last_word) begin
        wpos_nxt  = '0;
        tally_nxt = '0;
      end else begin
        wpos_nxt  = wpos_r + 1'b1;
        tally_nxt = tally_r + 2'(hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r  <= '0;
      tally_r <= '0;
    end else begin
      wpos_r  <= wpos_nxt;
      tally_r <= tally_nxt;
    end
  end

  // Held words of the group
  always_ff @(posedge clk) begin
    if (accept && !last_word) begin
      held_r[wpos_r[1:0]] <= data;
    end
  end

endmodule

// ===== rtl/hgd_queue.sv =====
// ----------------------------------------------------------------------------
// hgd_queue
// Small FIFO of finished groups between the front and back stages.
// ----------------------------------------------------------------------------
module hgd_queue
  import hgd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_group,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output group_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_r, wr_nxt;
  logic [PTR_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_group;
    end
  end

endmodule

// ===== rtl/hgd_back.sv =====
// ----------------------------------------------------------------------------
// hgd_back
// Drains one group at a time as thirteen registered output bytes.
// ----------------------------------------------------------------------------
module hgd_back
  import hgd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  group_t             q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_data_byte,
  output logic               out_last_byte,
  output logic [COUNT_W-1:0] out_corrected_count
);

  logic [GROUP_BITS-1:0] sh_r, sh_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BIDX_W-1:0]     idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  fire;
  logic                  at_last;

  assign fire    = busy_r & ~out_stall;
  assign at_last = (idx_r == BIDX_W'(GROUP_BYTES - 1));

  // Load a new group when idle or as the last byte leaves
  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    pop      = 1'b0;
    if (!busy_r || (fire && at_last)) begin
      if (!q_empty) begin
        pop      = 1'b1;
        sh_nxt   = q_head.bits;
        cnt_nxt  = q_head.count;
        idx_nxt  = '0;
        busy_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end else if (fire) begin
      sh_nxt  = sh_r >> BYTE_W;
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
  end

  assign out_valid           = busy_r;
  assign out_data_byte       = sh_r[BYTE_W-1:0];
  assign out_last_byte       = at_last;
  assign out_corrected_count = cnt_r;

endmodule

// ===== rtl/hamming_31_26_group_decoder.sv =====
// ----------------------------------------------------------------------------
// hamming_31_26_group_decoder
// Hamming (31,26) decoder that packs four corrected words into 13 bytes.
// ----------------------------------------------------------------------------
// The input side takes one codeword per cycle, corrects it in the same
// cycle and holds it until four words form a group; only the fourth word of
// a group can stall, and only when the group queue (QUEUE_DEPTH entries) is
// full. The output side sends each group as 13 bytes, one per cycle while
// out_stall is low, from a registered shift stage, so the byte port limits
// the sustained rate. With the output side idle, the first byte of a group
// is valid once the group is written to the queue and then loaded into the
// shift register; it transfers when out_stall is low. Every byte carries
// the group's count of words with a nonzero syndrome; the thirteenth is
// flagged last.
module hamming_31_26_group_decoder
  import hgd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CW_W-1:0]    in_codeword,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_data_byte,
  output logic               out_last_byte,
  output logic [COUNT_W-1:0] out_corrected_count
);

  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;
  group_t push_group;
  group_t q_head;

  // Correction and group assembly
  hgd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_codeword (in_codeword),
    .push        (push),
    .push_group  (push_group),
    .q_full      (q_full)
  );

  // Group queue
  hgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_group (push_group),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Byte serializer
  hgd_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_last_byte       (out_last_byte),
    .out_corrected_count (out_corrected_count)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the Hamming (31,26) group decoder. A queue-fed driver sends
// codewords with chosen syndromes (clean, parity-position, data-position)
// plus raw random words. A cycle-level predictor corrects each word, packs
// every group of four into 13 expected bytes, and the monitor checks each
// byte transfer in order. Traffic runs through several pacing phases,
// including a long receiver hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;
  import hgd_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 88;

  // Parity check masks, index k gives syndrome bit k
  localparam logic [PAR_W-1:0][DATA_W-1:0] CHECK_MASK = {
    26'd67106816, 26'd66848752, 26'd63162254, 26'd53687917, 26'd44739931
  };

  typedef enum logic [2:0] {
    PH_FREE,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH,
    PH_HOLD
  } pace_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               last_byte;
    logic [COUNT_W-1:0] corr_cnt;
  } group_byte_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [CW_W-1:0]    in_codeword = '0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_data_byte;
  logic               out_last_byte;
  logic [COUNT_W-1:0] out_corrected_count;

  pace_t              pace = PH_FREE;
  logic [CW_W-1:0]    codeword_q [$];
  group_byte_t        due_bytes [$];

  // Predictor state
  logic [DATA_W-1:0]  held_data [HELD_WORDS];
  int                 held_cnt  = 0;
  logic [COUNT_W-1:0] fix_tally = '0;

  logic               in_taken     = 1'b0;
  int                 hold_cnt     = 0;
  int                 stuck_cnt    = 0;
  int                 words_taken  = 0;
  int                 words_queued = 0;
  int                 fail_cnt     = 0;

  hamming_31_26_group_decoder u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_codeword         (in_codeword),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_last_byte       (out_last_byte),
    .out_corrected_count (out_corrected_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parity bits that make a data word check clean
  function automatic logic [PAR_W-1:0] check_bits(input logic [DATA_W-1:0] d);
    logic [PAR_W-1:0] c;
    for (int k = 0; k < PAR_W; k++) c[k] = ^(d & CHECK_MASK[k]);
    return c;
  endfunction

  // Codeword whose syndrome comes out as syn
  function automatic logic [CW_W-1:0] with_syndrome(input logic [DATA_W-1:0] d,
                                                    input logic [PAR_W-1:0] syn);
    return {check_bits(d) ^ syn, d};
  endfunction

  // Mostly well-formed words with a chosen syndrome, some raw noise
  function automatic logic [CW_W-1:0] draw_codeword();
    int                pick;
    logic [DATA_W-1:0] d;
    pick = $urandom_range(9);
    d    = DATA_W'($urandom);
    if ($urandom_range(15) == 0) d = $urandom_range(1) ? '1 : '0;
    if (pick < 4) return with_syndrome(d, '0);
    if (pick < 8) return with_syndrome(d, PAR_W'($urandom_range(31, 1)));
    return CW_W'($urandom);
  endfunction

  function automatic logic gap_roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Correct one word; on the fourth of a group, queue its 13 bytes
  task automatic decode_and_pack(input logic [CW_W-1:0] cw);
    logic [PAR_W-1:0]      syn;
    logic [DATA_W-1:0]     d;
    logic [GROUP_BITS-1:0] grp;
    logic [COUNT_W-1:0]    total;
    int                    pos;
    group_byte_t           gb;
    syn = check_bits(cw[DATA_W-1:0]) ^ cw[CW_W-1:DATA_W];
    d   = cw[DATA_W-1:0];
    // data bits sit at the non-power-of-two Hamming positions 3,5,6,7,9,...
    if (syn == 5'd3) pos = 0;
    else if (syn > 5'd4 && syn < 5'd8) pos = int'(syn) - 4;
    else if (syn > 5'd8 && syn < 5'd16) pos = int'(syn) - 5;
    else if (syn > 5'd16) pos = int'(syn) - 6;
    else pos = -1;
    if (pos >= 0) d[pos] = ~d[pos];
    if (held_cnt < HELD_WORDS) begin
      held_data[held_cnt] = d;
      fix_tally           = fix_tally + COUNT_W'(syn != '0);
      held_cnt            = held_cnt + 1;
    end else begin
      grp   = {d, held_data[2], held_data[1], held_data[0]};
      total = fix_tally + COUNT_W'(syn != '0);
      for (int b = 0; b < GROUP_BYTES; b++) begin
        gb.data_byte = grp[b*BYTE_W +: BYTE_W];
        gb.last_byte = (b == GROUP_BYTES - 1);
        gb.corr_cnt  = total;
        due_bytes.push_back(gb);
      end
      held_cnt  = 0;
      fix_tally = '0;
    end
  endtask

  // Input driver: holds a stalled transfer, otherwise offers the next word
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (codeword_q.size() > 0 &&
          !(pace == PH_SEND_GAPS && gap_roll(81)) &&
          !(pace == PH_BOTH && gap_roll(36))) begin
        in_valid    <= 1'b1;
        in_codeword <= codeword_q.pop_front();
      end else begin
        in_valid    <= 1'b0;
        in_codeword <= CW_W'($urandom);
      end
    end
  end

  // Output receiver: random stalls, or one long hold-off in the hold phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (pace == PH_HOLD) begin
      if (hold_cnt < HOLD_CYCLES) begin
        out_stall <= 1'b1;
        hold_cnt  <= hold_cnt + 1;
      end else begin
        out_stall <= 1'b0;
      end
    end else begin
      hold_cnt  <= 0;
      out_stall <= (pace == PH_RECV_STALLS && gap_roll(81)) ||
                   (pace == PH_BOTH && gap_roll(36));
    end
  end

  // Monitor: predict on input transfers, check output transfers, watchdog
  always @(posedge clk) begin : mon
    group_byte_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      stuck_cnt <= 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        decode_and_pack(in_codeword);
        words_taken <= words_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (due_bytes.size() == 0) begin
          $display("%0t: unexpected byte: data %h last %b count %0d", $time,
                   out_data_byte, out_last_byte, out_corrected_count);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = due_bytes.pop_front();
          if (out_data_byte !== want.data_byte) begin
            $display("%0t: data_byte expected %h actual %h", $time,
                     want.data_byte, out_data_byte);
            fail_cnt = fail_cnt + 1;
          end
          if (out_last_byte !== want.last_byte) begin
            $display("%0t: last_byte expected %b actual %b", $time,
                     want.last_byte, out_last_byte);
            fail_cnt = fail_cnt + 1;
          end
          if (out_corrected_count !== want.corr_cnt) begin
            $display("%0t: corrected_count expected %0d actual %0d", $time,
                     want.corr_cnt, out_corrected_count);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cnt <= 0;
      end else if (stuck_cnt >= STUCK_LIMIT) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, stuck_cnt);
        $display("Test completed with failures");
        $finish;
      end else begin
        stuck_cnt <= stuck_cnt + 1;
      end
    end
  end

  task automatic queue_word(input logic [CW_W-1:0] cw);
    codeword_q.push_back(cw);
    words_queued++;
  endtask

  task automatic run_phase(input pace_t p, input int n);
    pace = p;
    repeat (n) queue_word(draw_codeword());
    while (codeword_q.size() > 0) @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // all-zero group, no corrections
    repeat (4) queue_word(with_syndrome('0, 5'd0));
    // extremes: all-ones data, all-ones codeword, worst syndromes
    queue_word(with_syndrome('1, 5'd0));
    queue_word('1);
    queue_word(with_syndrome('0, 5'd31));
    queue_word(with_syndrome('1, 5'd3));
    // errors on parity positions only: data unchanged, still counted
    queue_word(with_syndrome(DATA_W'($urandom), 5'd1));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd2));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd4));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd8));
    // data-position errors around each parity gap, with a parity one mixed in
    queue_word(with_syndrome(DATA_W'($urandom), 5'd16));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd5));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd7));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd9));
    // full group of corrections
    queue_word(with_syndrome(DATA_W'($urandom), 5'd15));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd17));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd30));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd31));
    // mixed clean and corrected words
    queue_word(with_syndrome(DATA_W'($urandom), 5'd0));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd24));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd0));
    queue_word(with_syndrome(DATA_W'($urandom), 5'd6));
    while (codeword_q.size() > 0) @(posedge clk);

    run_phase(PH_FREE, PHASE_WORDS);
    run_phase(PH_SEND_GAPS, PHASE_WORDS);
    run_phase(PH_RECV_STALLS, PHASE_WORDS);
    run_phase(PH_BOTH, PHASE_WORDS);
    run_phase(PH_HOLD, PHASE_WORDS);

    while (words_taken != words_queued) @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/hgd_pkg.sv
rtl/hgd_front.sv
rtl/hgd_queue.sv
rtl/hgd_back.sv
rtl/hamming_31_26_group_decoder.sv
tb/tb_top.sv
